/* rtl/dfp_pkg.sv */
// ----------------------------------------------------------------------------
// dfp_pkg: shared types and constants of the distance-follow PID
// Field widths, fixed thresholds, register indexes and stage structs.
// ----------------------------------------------------------------------------
package dfp_pkg;

    localparam int DIST_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 15;
    localparam int DRIVE_W  = 16;
    localparam int ERR_W    = 8;
    localparam int DERIV_W  = 9;
    localparam int PROD_W   = GAIN_W + ERR_W;
    localparam int PRODD_W  = GAIN_W + DERIV_W;
    localparam int SUM_W    = PRODD_W + 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [DIST_W-1:0] DIST_FAR_LIMIT = 16'd2500;
    localparam logic [DIST_W-1:0] DIST_FAR_SUBST = 16'd1500;
    localparam logic [DIST_W:0]   ERR_DEADBAND   = 17'd5;
    localparam int                ERR_CLAMP      = 100;
    localparam int                SUM_CLAMP      = 100;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT = 4'd3;

    localparam logic signed [GAIN_W-1:0] GAIN_PROP_RST  = 16'sd128;
    localparam logic signed [GAIN_W-1:0] GAIN_INTEG_RST = 16'sd0;
    localparam logic signed [GAIN_W-1:0] GAIN_DERIV_RST = 16'sd0;
    localparam logic [LIMIT_W-1:0]       DRIVE_LIMIT_RST = 15'd100;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_prop;
        logic signed [GAIN_W-1:0] gain_integ;
        logic signed [GAIN_W-1:0] gain_deriv;
        logic [LIMIT_W-1:0]       drive_limit;
    } t_gains;

    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [ERR_W-1:0]   esum;
        logic signed [DERIV_W-1:0] deriv;
    } t_err_stage;

    typedef struct packed {
        logic load;
        logic advance;
    } t_stage_ctl;

endpackage

/* rtl/dfp_in_if.sv */
// ----------------------------------------------------------------------------
// dfp_in_if: input channel of the distance-follow PID
// One beat carries a target distance and a measured distance.
// ----------------------------------------------------------------------------
interface dfp_in_if;
    logic                        valid;
    logic                        ready;
    logic [dfp_pkg::DIST_W-1:0]  target_distance;
    logic [dfp_pkg::DIST_W-1:0]  measured_distance;

    modport source (output valid, output target_distance, output measured_distance,
                    input ready);
    modport sink   (input valid, input target_distance, input measured_distance,
                    output ready);
endinterface

/* rtl/dfp_out_if.sv */
// ----------------------------------------------------------------------------
// dfp_out_if: result channel of the distance-follow PID
// One beat carries the signed drive correction.
// ----------------------------------------------------------------------------
interface dfp_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [dfp_pkg::DRIVE_W-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

/* rtl/dfp_cfg_if.sv */
// ----------------------------------------------------------------------------
// dfp_cfg_if: register write channel of the distance-follow PID
// One beat writes data to the register selected by index.
// ----------------------------------------------------------------------------
interface dfp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dfp_pkg::CFG_IDX_W-1:0]     index;
    logic [dfp_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/dfp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// dfp_cfg_regs: gain and limit registers
// Decodes register writes; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module dfp_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [dfp_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [dfp_pkg::CFG_DATA_W-1:0] i_data,
    output dfp_pkg::t_gains               o_gains
);

    dfp_pkg::t_gains r_gains;
    dfp_pkg::t_gains n_gains;

    always_comb begin
        n_gains = r_gains;
        if (i_we) begin
            unique case (i_index)
                dfp_pkg::CFG_GAIN_PROP:   n_gains.gain_prop   = i_data;
                dfp_pkg::CFG_GAIN_INTEG:  n_gains.gain_integ  = i_data;
                dfp_pkg::CFG_GAIN_DERIV:  n_gains.gain_deriv  = i_data;
                dfp_pkg::CFG_DRIVE_LIMIT: n_gains.drive_limit = i_data[dfp_pkg::LIMIT_W-1:0];
                default:                  n_gains = r_gains;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.gain_prop   <= dfp_pkg::GAIN_PROP_RST;
            r_gains.gain_integ  <= dfp_pkg::GAIN_INTEG_RST;
            r_gains.gain_deriv  <= dfp_pkg::GAIN_DERIV_RST;
            r_gains.drive_limit <= dfp_pkg::DRIVE_LIMIT_RST;
        end else begin
            r_gains <= n_gains;
        end
    end

    assign o_gains = r_gains;

endmodule

/* rtl/dfp_error.sv */
// ----------------------------------------------------------------------------
// dfp_error: error, integral and derivative stage
// Forms the dead-banded clamped error and updates the loop state.
// ----------------------------------------------------------------------------
module dfp_error (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dfp_pkg::t_stage_ctl         i_ctl,
    input  logic [dfp_pkg::DIST_W-1:0]  i_target,
    input  logic [dfp_pkg::DIST_W-1:0]  i_measured,
    output dfp_pkg::t_err_stage         o_stage
);

    localparam int DW = dfp_pkg::DIST_W;
    localparam int EW = dfp_pkg::ERR_W;
    localparam int VW = dfp_pkg::DERIV_W;

    logic [DW-1:0]          actual_raw;
    logic [DW-1:0]          actual;
    logic signed [DW:0]     diff;
    logic [DW:0]            mag;
    logic signed [EW-1:0]   err;
    logic signed [VW-1:0]   sum_raw;
    logic signed [EW-1:0]   n_esum;
    logic signed [VW-1:0]   deriv;

    logic signed [EW-1:0]   r_esum;
    logic signed [EW-1:0]   r_prev;
    dfp_pkg::t_err_stage    r_stage;

    always_comb begin
        // no reading: follow the target
        actual_raw = (i_measured == '0) ? i_target : i_measured;
        actual     = (actual_raw > dfp_pkg::DIST_FAR_LIMIT) ? dfp_pkg::DIST_FAR_SUBST
                                                            : actual_raw;
        diff = $signed({1'b0, i_target}) - $signed({1'b0, actual});
        mag  = diff[DW] ? $unsigned(-diff) : $unsigned(diff);

        if (mag < dfp_pkg::ERR_DEADBAND)
            err = '0;
        else if (diff > (DW+1)'(dfp_pkg::ERR_CLAMP))
            err = EW'(dfp_pkg::ERR_CLAMP);
        else if (diff < -(DW+1)'(dfp_pkg::ERR_CLAMP))
            err = -EW'(dfp_pkg::ERR_CLAMP);
        else
            err = diff[EW-1:0];

        sum_raw = VW'(r_esum) + VW'(err);
        if (sum_raw > VW'(dfp_pkg::SUM_CLAMP))
            n_esum = EW'(dfp_pkg::SUM_CLAMP);
        else if (sum_raw < -VW'(dfp_pkg::SUM_CLAMP))
            n_esum = -EW'(dfp_pkg::SUM_CLAMP);
        else
            n_esum = sum_raw[EW-1:0];

        deriv = VW'(err) - VW'(r_prev);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esum <= '0;
            r_prev <= '0;
        end else if (i_ctl.load) begin
            r_esum <= n_esum;
            r_prev <= err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_stage.err   <= err;
            r_stage.esum  <= n_esum;
            r_stage.deriv <= deriv;
        end
    end

    assign o_stage = r_stage;

    a_esum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_esum <= EW'(dfp_pkg::SUM_CLAMP)) && (r_esum >= -EW'(dfp_pkg::SUM_CLAMP)))
        else $error("integral left its clamp range");

    a_prev_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load |=> (r_prev == r_stage.err) && (r_esum == r_stage.esum))
        else $error("loop state and stage register disagree");

endmodule

/* rtl/dfp_weight.sv */
// ----------------------------------------------------------------------------
// dfp_weight: gain products and output scaling
// Multiplies the three terms, then sums, scales, saturates, limits and negates.
// ----------------------------------------------------------------------------
module dfp_weight (
    input  logic                                i_clk,
    input  logic                                i_adv_prod,
    input  logic                                i_adv_out,
    input  dfp_pkg::t_err_stage                 i_stage,
    input  dfp_pkg::t_gains                     i_gains,
    output logic signed [dfp_pkg::DRIVE_W-1:0]  o_drive
);

    localparam int PW = dfp_pkg::PROD_W;
    localparam int QW = dfp_pkg::PRODD_W;
    localparam int SW = dfp_pkg::SUM_W;
    localparam int RW = SW - 8;
    localparam int OW = dfp_pkg::DRIVE_W;
    localparam int LW = dfp_pkg::LIMIT_W;

    logic signed [PW-1:0] prop_p;
    logic signed [PW-1:0] integ_p;
    logic signed [QW-1:0] deriv_p;
    logic signed [PW-1:0] r_prop_p;
    logic signed [PW-1:0] r_integ_p;
    logic signed [QW-1:0] r_deriv_p;

    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] sum_adj;
    logic signed [RW-1:0] scaled;
    logic signed [OW-1:0] sat;
    logic [OW:0]          mag;
    logic [OW:0]          limit_ext;
    logic signed [OW-1:0] limited;
    logic signed [OW-1:0] r_drive;

    assign prop_p  = i_gains.gain_prop  * i_stage.err;
    assign integ_p = i_gains.gain_integ * i_stage.esum;
    assign deriv_p = i_gains.gain_deriv * i_stage.deriv;

    always_ff @(posedge i_clk) begin
        if (i_adv_prod) begin
            r_prop_p  <= prop_p;
            r_integ_p <= integ_p;
            r_deriv_p <= deriv_p;
        end
    end

    always_comb begin
        sum = SW'(r_prop_p) + SW'(r_integ_p) + SW'(r_deriv_p);
        // bias negatives so the arithmetic shift truncates toward zero
        sum_adj = sum[SW-1] ? (sum + SW'(255)) : sum;
        scaled  = sum_adj[SW-1:8];

        if (scaled > RW'(32767))
            sat = 16'sh7FFF;
        else if (scaled < -RW'(32768))
            sat = 16'sh8000;
        else
            sat = scaled[OW-1:0];

        mag       = sat[OW-1] ? ((OW+1)'(0) - (OW+1)'(sat)) : (OW+1)'(sat);
        limit_ext = (OW+1)'(i_gains.drive_limit);

        if (mag >= limit_ext)
            limited = (sat > 0) ? $signed(OW'(i_gains.drive_limit))
                                : -$signed(OW'(i_gains.drive_limit));
        else
            limited = sat;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv_out)
            r_drive <= -limited;
    end

    assign o_drive = r_drive;

    // LW is narrower than the drive word, so the limited value never wraps
    if (LW >= OW) begin : g_bad_width
        $error("drive limit must be narrower than the drive word");
    end

endmodule

/* rtl/distance_follow_pid.sv */
// ----------------------------------------------------------------------------
// distance_follow_pid: positional PID speed correction for distance following
// Dead-banded clamped error, clamped integral, derivative, Q7.8 gains.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   carries one beat per control tick: target and measured distance.
//   o_out  returns exactly one beat per input beat: the negated, limited drive.
//   i_cfg  writes gain_prop (0), gain_integ (1), gain_deriv (2) and
//          drive_limit (3); other indexes are dropped. Write only while idle.
// Pipeline: input register, error/state stage, product stage, output register.
//   A result passes through these four registers in order and is valid once it
//   reaches the output register; a new beat is taken every cycle while the
//   receiver does not stall: one item per cycle.
// Each stage holds its beat while the stage after it is full and stalled, so
//   a stalled receiver fills the pipeline; up to four beats are held before
//   i_in.ready drops. Nothing is lost or repeated.
// Reset empties all stages, clears integral and previous error, and loads
//   the default gains (0.5, 0, 0) and a limit of 100. No clearing pass.
// ----------------------------------------------------------------------------
module distance_follow_pid (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dfp_in_if.sink    i_in,
    dfp_out_if.source o_out,
    dfp_cfg_if.sink   i_cfg
);

    localparam int DW = dfp_pkg::DIST_W;

    logic r_v_in;
    logic r_v_err;
    logic r_v_prod;
    logic r_v_out;

    logic adv_in;
    logic adv_err;
    logic adv_prod;
    logic adv_out;

    logic [DW-1:0] r_target;
    logic [DW-1:0] r_measured;

    dfp_pkg::t_gains     gains;
    dfp_pkg::t_err_stage err_stage;
    dfp_pkg::t_stage_ctl err_ctl;

    // a stage advances when it is empty or the next stage advances
    assign adv_out  = !r_v_out  || o_out.ready;
    assign adv_prod = !r_v_prod || adv_out;
    assign adv_err  = !r_v_err  || adv_prod;
    assign adv_in   = !r_v_in   || adv_err;

    assign i_in.ready  = adv_in;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in   <= 1'b0;
            r_v_err  <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            if (adv_in)   r_v_in   <= i_in.valid;
            if (adv_err)  r_v_err  <= r_v_in;
            if (adv_prod) r_v_prod <= r_v_err;
            if (adv_out)  r_v_out  <= r_v_prod;
        end
    end

    // capture the input beat
    always_ff @(posedge i_clk) begin
        if (adv_in) begin
            r_target   <= i_in.target_distance;
            r_measured <= i_in.measured_distance;
        end
    end

    dfp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_gains (gains)
    );

    // loop state moves only when a real beat leaves the input register
    assign err_ctl.load    = r_v_in && adv_err;
    assign err_ctl.advance = adv_err;

    dfp_error u_err (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (err_ctl),
        .i_target   (r_target),
        .i_measured (r_measured),
        .o_stage    (err_stage)
    );

    dfp_weight u_wgt (
        .i_clk      (i_clk),
        .i_adv_prod (adv_prod),
        .i_adv_out  (adv_out),
        .i_stage    (err_stage),
        .i_gains    (gains),
        .o_drive    (o_out.drive)
    );

    assign o_out.valid = r_v_out;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid && !r_v_in)
        else $error("pipeline not empty after reset");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_v_in)
        else $error("accepted beat did not reach the input register");

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.drive != 16'sh8000))
        else $error("drive left its symmetric range");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v_prod && r_v_out && !o_out.ready) |=> r_v_prod)
        else $error("product stage dropped a beat under stall");

endmodule
